// ===== rtl/core/abpw_pkg.sv =====
// ----------------------------------------------------------------------------
// abpw_pkg
// Shared types and constants of the alpha blend pixel writer: request
// payloads, result payloads and configuration register indexes.
// ----------------------------------------------------------------------------
package abpw_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 27;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_ROW_PITCH     = 3'd2,
		REG_PIXEL_MODE    = 3'd3,
		REG_BUFFER_BYTES  = 3'd4,
		REG_SCROLL_BYTES  = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		KIND_PLOT = 1'b0,
		KIND_SWAP = 1'b1
	} kind_t;

	typedef enum logic {
		MODE_24BPP = 1'b0,
		MODE_32BPP = 1'b1
	} pixel_mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [31:0] old_pixel;
	} abpw_item_t;

	typedef struct packed {
		logic        write_enable;
		logic [25:0] byte_address;
		logic [31:0] new_pixel;
		logic [2:0]  bytes_written;
		logic        rect_valid;
		logic [11:0] rect_left;
		logic [11:0] rect_top;
		logic [12:0] rect_right;
		logic [12:0] rect_bottom;
	} abpw_result_t;

endpackage

// ===== rtl/core/abpw_if.sv =====
// ----------------------------------------------------------------------------
// abpw_if
// Channel interfaces of the alpha blend pixel writer: plot and swap
// requests, results, and configuration writes.
// ----------------------------------------------------------------------------
interface abpw_item_if import abpw_pkg::*; ();
	logic       valid;
	logic       ready;
	abpw_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface abpw_result_if import abpw_pkg::*; ();
	logic         valid;
	logic         ready;
	abpw_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface abpw_cfg_if import abpw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/alpha_blend_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// alpha_blend_pixel_writer
// Plot requests give a wrapped framebuffer byte address and the word to
// store, alpha blended with the old word in 32 bpp mode; swap requests
// report and reset the dirty rectangle grown by the visible plots.
//
// The block takes one request per clock while the result side is not
// stalled, and returns exactly one result per request, in order, through
// an input register, a register after the row-pitch and channel
// multipliers, and the result register. The dirty rectangle is updated as a
// request leaves the input register, so a swap sees every earlier plot.
// Configuration writes are always ready and must be made while the block is
// idle. Points at or beyond the visible width or height (each limited to
// MAX_SCREEN_DIM) are not written and leave the rectangle unchanged.
// ----------------------------------------------------------------------------
module alpha_blend_pixel_writer import abpw_pkg::*; #(
	parameter int MAX_SCREEN_DIM = 4096
) (
	input  logic   clk,
	input  logic   arst_n,
	abpw_item_if.sink     plot,
	abpw_result_if.source result,
	abpw_cfg_if.sink      cfg
);

	localparam logic [13:0] MaxDimW = 14'(MAX_SCREEN_DIM);
	localparam logic [12:0] MaxDim  = 13'(MAX_SCREEN_DIM);

	// configuration
	logic [12:0] screen_width_q;
	logic [12:0] screen_height_q;
	logic [14:0] row_pitch_q;
	pixel_mode_t pixel_mode_q;
	logic [26:0] buffer_bytes_q;
	logic [25:0] scroll_bytes_q;

	// dirty rectangle
	logic [12:0] dirty_left_q;
	logic [12:0] dirty_top_q;
	logic [12:0] dirty_right_q;
	logic [12:0] dirty_bottom_q;

	// pipeline
	logic        vld_s1;
	abpw_item_t  item_s1;
	logic        vld_s2;
	kind_t       kind_s2;
	logic        on_screen_s2;
	pixel_mode_t mode_s2;
	logic [7:0]  red_s2;
	logic [7:0]  green_s2;
	logic [7:0]  blue_s2;
	logic [7:0]  alpha_s2;
	logic [26:0] row_off_s2;
	logic [13:0] col_off_s2;
	logic [15:0] prod_src_s2 [3];
	logic [15:0] prod_old_s2 [3];
	logic        rect_valid_s2;
	logic [11:0] rect_left_s2;
	logic [11:0] rect_top_s2;
	logic [12:0] rect_right_s2;
	logic [12:0] rect_bottom_s2;
	logic         vld_s3;
	abpw_result_t res_s3;
	abpw_result_t res_nxt;

	logic out_free;
	logic load_s2;
	logic move_s1;

	assign out_free = !vld_s3 || result.ready;
	assign load_s2  = !vld_s2 || out_free;
	assign move_s1  = vld_s1 && load_s2;

	assign plot.ready   = !vld_s1 || load_s2;
	assign cfg.ready    = 1'b1;
	assign result.valid = vld_s3;
	assign result.data  = res_s3;

	// ---------------- stage 1: visibility, rectangle, products ----------------
	logic [12:0] vis_w;
	logic [12:0] vis_h;
	logic [12:0] x_ext;
	logic [12:0] y_ext;
	logic [12:0] x_inc;
	logic [12:0] y_inc;
	logic        on_screen;
	logic [12:0] nxt_left;
	logic [12:0] nxt_top;
	logic [12:0] grow_right;
	logic [12:0] grow_bottom;
	logic [12:0] nxt_right;
	logic [12:0] nxt_bottom;
	logic        rect_nonempty;
	logic [26:0] row_off;
	logic [13:0] col_off;
	logic [7:0]  alpha_inv;
	logic [7:0]  src_ch [3];
	logic [7:0]  old_ch [3];

	always_comb begin
		vis_w = ({1'b0, screen_width_q} > MaxDimW) ? MaxDim : screen_width_q;
		vis_h = ({1'b0, screen_height_q} > MaxDimW) ? MaxDim : screen_height_q;
		x_ext = {1'b0, item_s1.pos_x};
		y_ext = {1'b0, item_s1.pos_y};
		x_inc = x_ext + 13'd1;
		y_inc = y_ext + 13'd1;
		on_screen = (x_ext < vis_w) && (y_ext < vis_h);

		nxt_left    = (x_ext < dirty_left_q) ? x_ext : dirty_left_q;
		nxt_top     = (y_ext < dirty_top_q) ? y_ext : dirty_top_q;
		grow_right  = (x_inc > dirty_right_q) ? x_inc : dirty_right_q;
		grow_bottom = (y_inc > dirty_bottom_q) ? y_inc : dirty_bottom_q;
		nxt_right   = (grow_right > vis_w) ? vis_w : grow_right;
		nxt_bottom  = (grow_bottom > vis_h) ? vis_h : grow_bottom;

		rect_nonempty = (dirty_left_q < dirty_right_q) && (dirty_top_q < dirty_bottom_q);

		row_off = {15'd0, item_s1.pos_y} * {12'd0, row_pitch_q};
		if (pixel_mode_q == MODE_32BPP) begin
			col_off = {item_s1.pos_x, 2'b00};
		end else begin
			col_off = {1'b0, item_s1.pos_x, 1'b0} + {2'b00, item_s1.pos_x};
		end

		alpha_inv = 8'd255 - item_s1.alpha;
		src_ch[0] = item_s1.blue;
		src_ch[1] = item_s1.green;
		src_ch[2] = item_s1.red;
		old_ch[0] = item_s1.old_pixel[7:0];
		old_ch[1] = item_s1.old_pixel[15:8];
		old_ch[2] = item_s1.old_pixel[23:16];
	end

	// ---------------- configuration and dirty rectangle ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= 13'd1024;
			screen_height_q <= 13'd768;
			row_pitch_q     <= 15'd4096;
			pixel_mode_q    <= MODE_32BPP;
			buffer_bytes_q  <= 27'd3145728;
			scroll_bytes_q  <= 26'd0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg.data[12:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg.data[12:0];
				REG_ROW_PITCH:     row_pitch_q     <= cfg.data[14:0];
				REG_PIXEL_MODE:    pixel_mode_q    <= pixel_mode_t'(cfg.data[0]);
				REG_BUFFER_BYTES:  buffer_bytes_q  <= cfg.data[26:0];
				REG_SCROLL_BYTES:  scroll_bytes_q  <= cfg.data[25:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_left_q   <= '1;
			dirty_top_q    <= '1;
			dirty_right_q  <= '0;
			dirty_bottom_q <= '0;
		end else if (move_s1) begin
			if (item_s1.kind == KIND_SWAP) begin
				dirty_left_q   <= '1;
				dirty_top_q    <= '1;
				dirty_right_q  <= '0;
				dirty_bottom_q <= '0;
			end else if (on_screen) begin
				dirty_left_q   <= nxt_left;
				dirty_top_q    <= nxt_top;
				dirty_right_q  <= nxt_right;
				dirty_bottom_q <= nxt_bottom;
			end
		end
	end

	// ---------------- pipeline valids ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (plot.ready) begin
				vld_s1 <= plot.valid;
			end
			if (load_s2) begin
				vld_s2 <= vld_s1;
			end
			if (out_free) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (plot.valid && plot.ready) begin
			item_s1 <= plot.data;
		end
		if (move_s1) begin
			kind_s2        <= item_s1.kind;
			on_screen_s2   <= on_screen;
			mode_s2        <= pixel_mode_q;
			red_s2         <= item_s1.red;
			green_s2       <= item_s1.green;
			blue_s2        <= item_s1.blue;
			alpha_s2       <= item_s1.alpha;
			row_off_s2     <= row_off;
			col_off_s2     <= col_off;
			for (int c = 0; c < 3; c++) begin
				prod_src_s2[c] <= {8'd0, src_ch[c]} * {8'd0, item_s1.alpha};
				prod_old_s2[c] <= {8'd0, old_ch[c]} * {8'd0, alpha_inv};
			end
			rect_valid_s2  <= rect_nonempty;
			rect_left_s2   <= rect_nonempty ? dirty_left_q[11:0] : 12'd0;
			rect_top_s2    <= rect_nonempty ? dirty_top_q[11:0] : 12'd0;
			rect_right_s2  <= rect_nonempty ? dirty_right_q : 13'd0;
			rect_bottom_s2 <= rect_nonempty ? dirty_bottom_q : 13'd0;
		end
		if (vld_s2 && out_free) begin
			res_s3 <= res_nxt;
		end
	end

	// ---------------- stage 2: address wrap, blend ----------------
	logic [27:0]  addr_sum;
	logic [27:0]  addr_wrap;
	logic [15:0]  mix_sum [3];
	logic [16:0]  mix_q17 [3];
	logic [7:0]   mix_ch [3];
	logic [31:0]  word;

	always_comb begin
		addr_sum = {1'b0, row_off_s2} + {14'd0, col_off_s2} + {2'd0, scroll_bytes_q};
		addr_wrap = (addr_sum >= {1'b0, buffer_bytes_q}) ?
			addr_sum - {1'b0, buffer_bytes_q} : addr_sum;

		// divide by 255, exact over the blend range
		for (int c = 0; c < 3; c++) begin
			mix_sum[c] = prod_src_s2[c] + prod_old_s2[c];
			mix_q17[c] = ({1'b0, mix_sum[c]} + 17'd1 + {9'd0, mix_sum[c][15:8]}) >> 8;
			mix_ch[c]  = mix_q17[c][7:0];
		end

		if (mode_s2 == MODE_24BPP) begin
			word = {8'd0, red_s2, green_s2, blue_s2};
		end else if (alpha_s2 != 8'd255) begin
			word = {alpha_s2, mix_ch[2], mix_ch[1], mix_ch[0]};
		end else begin
			word = {alpha_s2, red_s2, green_s2, blue_s2};
		end

		res_nxt = '0;
		if (kind_s2 == KIND_SWAP) begin
			res_nxt.rect_valid  = rect_valid_s2;
			res_nxt.rect_left   = rect_left_s2;
			res_nxt.rect_top    = rect_top_s2;
			res_nxt.rect_right  = rect_right_s2;
			res_nxt.rect_bottom = rect_bottom_s2;
		end else if (on_screen_s2) begin
			res_nxt.write_enable  = 1'b1;
			res_nxt.byte_address  = addr_wrap[25:0];
			res_nxt.new_pixel     = word;
			res_nxt.bytes_written = (mode_s2 == MODE_32BPP) ? 3'd4 : 3'd3;
		end
	end

	// ---------------- assertions ----------------
	a_plot_no_rect: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.write_enable |-> !result.data.rect_valid)
		else $error("plot result carries a dirty rectangle");

	a_bytes_written: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.write_enable |->
			(result.data.bytes_written == 3'd3 || result.data.bytes_written == 3'd4))
		else $error("bytes written is neither 3 nor 4");

	a_rect_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.rect_valid |->
			({1'b0, result.data.rect_left} < result.data.rect_right) &&
			({1'b0, result.data.rect_top} < result.data.rect_bottom))
		else $error("reported rectangle is empty");

	a_dirty_limit: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, dirty_right_q} <= MaxDimW && {1'b0, dirty_bottom_q} <= MaxDimW)
		else $error("dirty rectangle beyond the largest screen");

	a_swap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 && item_s1.kind == KIND_SWAP |=>
			dirty_right_q == 13'd0 && dirty_bottom_q == 13'd0)
		else $error("swap did not reset the dirty rectangle");

endmodule

// ===== tb/tb_alpha_blend_pixel_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_blend_pixel_writer
// Self-checking bench for the alpha blend pixel writer. A table of opening
// requests runs under reset settings, then random plot and swap streams
// run under several screen, pitch, mode and wrap settings, with idling on
// both channels. Each result is checked field by field against the table
// for typed rows, else an in-bench model of address, blend, dirty rectangle.
// ----------------------------------------------------------------------------
module tb_alpha_blend_pixel_writer;
	import abpw_pkg::*;

	localparam int MaxDim     = 4096;
	localparam int CycleLimit = 500000;
	localparam int PhaseReqs  = 216;

	typedef struct {
		abpw_item_t   req;
		bit           typed;
		abpw_result_t want;
	} opening_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	abpw_item_if   plot_if ();
	abpw_result_if res_if ();
	abpw_cfg_if    cfg_if ();

	alpha_blend_pixel_writer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.plot   (plot_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	always #4 clk = ~clk;

	// Shadow of the configuration and dirty rectangle
	logic [12:0]  scr_w   = 13'd1024;
	logic [12:0]  scr_h   = 13'd768;
	logic [14:0]  pitch   = 15'd4096;
	pixel_mode_t  mode    = MODE_32BPP;
	logic [26:0]  buf_sz  = 27'd3145728;
	logic [25:0]  scroll  = 26'd0;
	logic [12:0]  dirty_l = '1;
	logic [12:0]  dirty_t = '1;
	logic [12:0]  dirty_r = '0;
	logic [12:0]  dirty_b = '0;

	abpw_result_t pixel_results_due[$];
	opening_row_t opening_rows[$];
	logic         req_typed = 1'b0;
	abpw_result_t req_want = '0;
	int           err_count = 0;
	int           cycles = 0;
	int           send_pct = 0;
	int           stall_pct = 0;

	function automatic logic [12:0] visible(logic [12:0] dim);
		return (dim > MaxDim) ? 13'(MaxDim) : dim;
	endfunction

	function automatic logic [7:0] mix_channel(logic [7:0] c, logic [7:0] o, logic [7:0] a);
		logic [31:0] acc;
		acc = 32'(c) * 32'(a) + 32'(o) * (32'd255 - 32'(a));
		return 8'(acc / 32'd255);
	endfunction

	function automatic abpw_result_t blend_and_track(abpw_item_t it);
		abpw_result_t r;
		logic [12:0]  vw;
		logic [12:0]  vh;
		logic [63:0]  offs;
		logic [2:0]   bpp;
		r = '0;
		vw = visible(scr_w);
		vh = visible(scr_h);
		if (it.kind == KIND_SWAP) begin
			if (dirty_l < dirty_r && dirty_t < dirty_b) begin
				r.rect_valid  = 1'b1;
				r.rect_left   = dirty_l[11:0];
				r.rect_top    = dirty_t[11:0];
				r.rect_right  = dirty_r;
				r.rect_bottom = dirty_b;
			end
			dirty_l = '1;
			dirty_t = '1;
			dirty_r = '0;
			dirty_b = '0;
			return r;
		end
		if ({1'b0, it.pos_x} >= vw || {1'b0, it.pos_y} >= vh)
			return r;
		if ({1'b0, it.pos_x} < dirty_l) dirty_l = {1'b0, it.pos_x};
		if ({1'b0, it.pos_y} < dirty_t) dirty_t = {1'b0, it.pos_y};
		if ({1'b0, it.pos_x} + 13'd1 > dirty_r) dirty_r = {1'b0, it.pos_x} + 13'd1;
		if ({1'b0, it.pos_y} + 13'd1 > dirty_b) dirty_b = {1'b0, it.pos_y} + 13'd1;
		if (dirty_r > vw) dirty_r = vw;
		if (dirty_b > vh) dirty_b = vh;
		bpp = (mode == MODE_32BPP) ? 3'd4 : 3'd3;
		offs = 64'(it.pos_y) * 64'(pitch) + 64'(it.pos_x) * 64'(bpp) + 64'(scroll);
		if (offs >= 64'(buf_sz))
			offs = offs - 64'(buf_sz);
		r.write_enable  = 1'b1;
		r.byte_address  = offs[25:0];
		r.bytes_written = bpp;
		if (mode == MODE_24BPP)
			r.new_pixel = {8'h00, it.red, it.green, it.blue};
		else if (it.alpha != 8'hFF)
			r.new_pixel = {it.alpha, mix_channel(it.red, it.old_pixel[23:16], it.alpha),
				mix_channel(it.green, it.old_pixel[15:8], it.alpha),
				mix_channel(it.blue, it.old_pixel[7:0], it.alpha)};
		else
			r.new_pixel = {it.alpha, it.red, it.green, it.blue};
		return r;
	endfunction

	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endfunction

	function automatic abpw_result_t plot_out(logic [25:0] addr, logic [31:0] pix, logic [2:0] bw);
		abpw_result_t r;
		r = '0;
		r.write_enable  = 1'b1;
		r.byte_address  = addr;
		r.new_pixel     = pix;
		r.bytes_written = bw;
		return r;
	endfunction

	function automatic abpw_result_t rect_out(logic [11:0] l, logic [11:0] t,
		logic [12:0] rt, logic [12:0] b);
		abpw_result_t r;
		r = '0;
		r.rect_valid  = 1'b1;
		r.rect_left   = l;
		r.rect_top    = t;
		r.rect_right  = rt;
		r.rect_bottom = b;
		return r;
	endfunction

	function automatic void add_row(kind_t k, logic [11:0] x, logic [11:0] y, logic [7:0] r,
		logic [7:0] g, logic [7:0] b, logic [7:0] a, logic [31:0] old, bit typed,
		abpw_result_t want);
		opening_row_t row;
		row.req.kind      = k;
		row.req.pos_x     = x;
		row.req.pos_y     = y;
		row.req.red       = r;
		row.req.green     = g;
		row.req.blue      = b;
		row.req.alpha     = a;
		row.req.old_pixel = old;
		row.typed         = typed;
		row.want          = want;
		opening_rows.push_back(row);
	endfunction

	always @(posedge clk) begin : watch
		abpw_result_t want;
		abpw_result_t got;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_reg_t'(cfg_if.index))
					REG_SCREEN_WIDTH:  scr_w = cfg_if.data[12:0];
					REG_SCREEN_HEIGHT: scr_h = cfg_if.data[12:0];
					REG_ROW_PITCH:     pitch = cfg_if.data[14:0];
					REG_PIXEL_MODE:    mode = pixel_mode_t'(cfg_if.data[0]);
					REG_BUFFER_BYTES:  buf_sz = cfg_if.data[26:0];
					REG_SCROLL_BYTES:  scroll = cfg_if.data[25:0];
					default: ;
				endcase
			end
			if (plot_if.valid && plot_if.ready) begin
				want = blend_and_track(plot_if.data);
				if (req_typed)
					want = req_want;
				pixel_results_due.push_back(want);
			end
			if (res_if.valid && res_if.ready) begin
				got = res_if.data;
				if (pixel_results_due.size() == 0) begin
					$error("result with no request outstanding");
					err_count++;
				end else begin
					want = pixel_results_due.pop_front();
					cmp_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
					cmp_field("byte_address", 32'(want.byte_address), 32'(got.byte_address));
					cmp_field("new_pixel", want.new_pixel, got.new_pixel);
					cmp_field("bytes_written", 32'(want.bytes_written), 32'(got.bytes_written));
					cmp_field("rect_valid", 32'(want.rect_valid), 32'(got.rect_valid));
					cmp_field("rect_left", 32'(want.rect_left), 32'(got.rect_left));
					cmp_field("rect_top", 32'(want.rect_top), 32'(got.rect_top));
					cmp_field("rect_right", 32'(want.rect_right), 32'(got.rect_right));
					cmp_field("rect_bottom", 32'(want.rect_bottom), 32'(got.rect_bottom));
				end
			end
		end
	end

	always @(negedge clk)
		res_if.ready <= ($urandom_range(0, 99) >= stall_pct);

	task automatic send_req(abpw_item_t it, bit typed, abpw_result_t want);
		@(negedge clk);
		plot_if.valid <= 1'b1;
		plot_if.data  <= it;
		req_typed     <= typed;
		req_want      <= want;
		do @(posedge clk); while (!plot_if.ready);
	endtask

	task automatic hold_off(int n);
		@(negedge clk);
		plot_if.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		hold_off(1);
		while (pixel_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_screen(logic [12:0] w, logic [12:0] h, logic [14:0] p,
		pixel_mode_t m, logic [26:0] bsz, logic [25:0] sc);
		write_reg(REG_SCREEN_WIDTH, 27'(w));
		write_reg(REG_SCREEN_HEIGHT, 27'(h));
		write_reg(REG_ROW_PITCH, 27'(p));
		write_reg(REG_PIXEL_MODE, 27'(m));
		write_reg(REG_BUFFER_BYTES, bsz);
		write_reg(REG_SCROLL_BYTES, 27'(sc));
	endtask

	task automatic run_phase(int n_reqs);
		abpw_item_t   it;
		logic [12:0]  vw;
		logic [12:0]  vh;
		int           gap;
		int           sel;
		for (int i = 0; i < n_reqs; i++) begin
			vw = visible(scr_w);
			vh = visible(scr_h);
			it.kind = ($urandom_range(0, 99) < 7) ? KIND_SWAP : KIND_PLOT;
			if (vw != 0 && $urandom_range(0, 99) < 88)
				it.pos_x = 12'($urandom_range(0, vw - 1));
			else
				it.pos_x = 12'($urandom);
			if (vh != 0 && $urandom_range(0, 99) < 88)
				it.pos_y = 12'($urandom_range(0, vh - 1));
			else
				it.pos_y = 12'($urandom);
			it.red   = 8'($urandom);
			it.green = 8'($urandom);
			it.blue  = 8'($urandom);
			sel = $urandom_range(0, 9);
			if (sel == 0)
				it.alpha = 8'h00;
			else if (sel < 3)
				it.alpha = 8'hFF;
			else
				it.alpha = 8'($urandom);
			it.old_pixel = $urandom;
			// let the pipe run dry now and then
			if ($urandom_range(0, 199) == 0)
				drain();
			gap = 0;
			while (gap < 60 && $urandom_range(0, 99) < send_pct)
				gap++;
			if (gap > 0)
				hold_off(gap);
			send_req(it, 1'b0, '0);
		end
		drain();
	endtask

	initial begin
		plot_if.valid = 1'b0;
		plot_if.data  = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.index  = '0;
		cfg_if.data   = '0;

		add_row(KIND_SWAP, 0, 0, 0, 0, 0, 0, 0, 1, '0);
		add_row(KIND_PLOT, 0, 0, 8'hFF, 8'h00, 8'h80, 8'hFF, 32'h12345678, 1,
			plot_out(26'd0, 32'hFFFF0080, 3'd4));
		add_row(KIND_PLOT, 1023, 767, 8'hFF, 8'hFF, 8'hFF, 8'h00, 32'hA1B2C3D4, 1,
			plot_out(26'd3145724, 32'h00B2C3D4, 3'd4));
		add_row(KIND_SWAP, 0, 0, 0, 0, 0, 0, 0, 1, rect_out(0, 0, 13'd1024, 13'd768));
		add_row(KIND_SWAP, 0, 0, 0, 0, 0, 0, 0, 1, '0);
		add_row(KIND_PLOT, 1024, 0, 8'h11, 8'h22, 8'h33, 8'hFF, 0, 1, '0);
		add_row(KIND_PLOT, 0, 768, 8'h11, 8'h22, 8'h33, 8'h80, 0, 1, '0);
		add_row(KIND_PLOT, 4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 1, '0);
		add_row(KIND_SWAP, 4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 1, '0);
		add_row(KIND_PLOT, 5, 7, 8'h40, 8'h80, 8'hC0, 8'd128, 32'h00FF7F01, 0, '0);
		add_row(KIND_PLOT, 100, 200, 8'hFF, 8'h00, 8'hFF, 8'd1, 32'h5A5A5A5A, 0, '0);
		add_row(KIND_PLOT, 3, 2, 8'h00, 8'hFF, 8'h00, 8'd254, 32'hFFFFFFFF, 0, '0);
		add_row(KIND_PLOT, 12'h3FF, 12'h2FF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 32'hFFFFFFFF, 0, '0);
		add_row(KIND_SWAP, 0, 0, 0, 0, 0, 0, 0, 0, '0);
		add_row(KIND_PLOT, 512, 300, 8'h00, 8'h00, 8'h00, 8'hFF, 0, 0, '0);
		add_row(KIND_SWAP, 0, 0, 0, 0, 0, 0, 0, 1, rect_out(12'd512, 12'd300, 13'd513, 13'd301));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_rows[i])
			send_req(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].want);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_pct = 0;  stall_pct = 0;  end
				1: begin send_pct = 85; stall_pct = 0;  end
				2: begin send_pct = 0;  stall_pct = 85; end
				default: begin send_pct = 30; stall_pct = 30; end
			endcase
			case (p)
				0: set_screen(16, 12, 64, MODE_32BPP, 768, 700);
				1: set_screen(20, 9, 3, MODE_24BPP, 500, 0);
				2: set_screen(4096, 4096, 16384, MODE_32BPP, 27'd67108864, 26'd67108863);
				3: set_screen(1, 1, 3, MODE_24BPP, 1, 0);
				4: set_screen(0, 0, 100, MODE_32BPP, 0, 5);
				5: set_screen(13'h1FFF, 13'h1FFF, 15'h7FFF, MODE_24BPP, 27'h7FFFFFF,
					26'h3FFFFFF);
				6: set_screen(640, 480, 2560, MODE_32BPP, 0, 12345);
				default: set_screen(13'($urandom_range(1, 300)), 13'($urandom_range(1, 300)),
					15'($urandom_range(3, 2000)), pixel_mode_t'($urandom_range(0, 1)),
					27'($urandom_range(1, 67108864)), 26'($urandom));
			endcase
			run_phase(PhaseReqs);
		end

		if (err_count == 0 && pixel_results_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
